@@ design/pli_pkg.sv @@
// Package for the piecewise linear interpolator: widths, codes and the structs that
// travel between the table, multiplier, divider and output buffer stages.
// Depends on nothing; every other design file refers to it by scoped names.
package pli_pkg;

    localparam int DATA_W         = 32;
    localparam int PT_IDX_W       = 4;
    localparam int CNT_W          = 5;
    localparam int PT_SLOTS       = 2 ** PT_IDX_W;
    localparam int DEF_MAX_POINTS = 16;
    localparam int DIV_W          = 32;
    localparam int PROD_W         = 2 * DIV_W;

    localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [0:0] {
        FUNC_LOAD = 1'b0,
        FUNC_EVAL = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        REGION_BELOW    = 2'd0,
        REGION_INTERIOR = 2'd1,
        REGION_ABOVE    = 2'd2
    } t_region;

    // One breakpoint write.
    typedef struct packed {
        logic [PT_IDX_W-1:0]      idx;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
    } t_wr;

    // Segment chosen for a query, with both end points read from the table.
    typedef struct packed {
        logic signed [DATA_W-1:0] q;
        logic signed [DATA_W-1:0] xl;
        logic signed [DATA_W-1:0] xr;
        logic signed [DATA_W-1:0] yl;
        logic signed [DATA_W-1:0] yr;
        logic [PT_IDX_W-1:0]      seg;
        t_region                  region;
    } t_seg;

    // What a query carries past the arithmetic to the final add.
    typedef struct packed {
        logic signed [DATA_W-1:0] base;
        logic                     neg;
        logic [PT_IDX_W-1:0]      seg;
        t_region                  region;
    } t_tag;

    // Operands handed to the divider.
    typedef struct packed {
        logic [PROD_W-1:0] num;
        logic [DIV_W-1:0]  dv;
        t_tag              tag;
    } t_div_in;

    typedef struct packed {
        logic [DATA_W-1:0]   result_y;
        logic [PT_IDX_W-1:0] segment;
        t_region             region;
    } t_res;

endpackage

@@ design/pli_ifs.sv @@
// Valid/ready channel interfaces for the interpolator's input and result streams.
// Depends on pli_pkg for the field widths.
interface pli_in_if;
    logic                               valid;
    logic                               ready;
    logic                               func;
    logic [pli_pkg::PT_IDX_W-1:0]       point_index;
    logic signed [pli_pkg::DATA_W-1:0]  point_x;
    logic signed [pli_pkg::DATA_W-1:0]  point_y;
    logic signed [pli_pkg::DATA_W-1:0]  query_x;

    modport source (output valid, func, point_index, point_x, point_y, query_x, input ready);
    modport sink   (input valid, func, point_index, point_x, point_y, query_x, output ready);
endinterface

interface pli_out_if;
    logic                         valid;
    logic                         ready;
    logic [pli_pkg::DATA_W-1:0]   result_y;
    logic [pli_pkg::PT_IDX_W-1:0] segment;
    logic [1:0]                   region;

    modport source (output valid, result_y, segment, region, input ready);
    modport sink   (input valid, result_y, segment, region, output ready);
endinterface

@@ design/pli_table.sv @@
// Breakpoint storage and segment search: three stages (query, compare, table read).
// Depends on pli_pkg.
module pli_table #(
    parameter int MAX_POINTS = pli_pkg::DEF_MAX_POINTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_wr_en,
    input  pli_pkg::t_wr                      i_wr,
    input  logic                              i_ev_en,
    input  logic signed [pli_pkg::DATA_W-1:0] i_q,
    input  logic [pli_pkg::CNT_W-1:0]         i_point_count,
    output logic                              o_busy,
    output logic                              o_vld,
    output pli_pkg::t_seg                     o_seg
);

    // Only PT_SLOTS slots can ever be addressed by a load.
    localparam int TAB_DEPTH = (MAX_POINTS < pli_pkg::PT_SLOTS) ? MAX_POINTS
                                                                : pli_pkg::PT_SLOTS;
    localparam int IW = $clog2(TAB_DEPTH);
    localparam int CW = pli_pkg::CNT_W;
    localparam int XW = pli_pkg::PT_IDX_W;
    localparam int DW = pli_pkg::DATA_W;

    logic signed [DW-1:0] r_xf [TAB_DEPTH];
    logic signed [DW-1:0] r_xm [TAB_DEPTH];
    logic signed [DW-1:0] r_ym [TAB_DEPTH];

    logic                 r_s1_vld;
    logic signed [DW-1:0] r_s1_q;
    logic                 r_s2_vld;
    logic signed [DW-1:0] r_s2_q;
    logic [TAB_DEPTH-1:0] r_s2_lt;
    logic [IW-1:0]        r_s2_last;
    logic                 r_s3_vld;
    logic signed [DW-1:0] r_s3_q;
    logic signed [DW-1:0] r_s3_xl;
    logic signed [DW-1:0] r_s3_xr;
    logic signed [DW-1:0] r_s3_yl;
    logic signed [DW-1:0] r_s3_yr;
    logic [IW-1:0]        r_s3_seg;
    pli_pkg::t_region     r_s3_region;

    logic                 wr_ok;
    logic [IW-1:0]        wa;
    logic [TAB_DEPTH-1:0] n_lt;
    logic [IW-1:0]        n_last;
    logic [IW-1:0]        sel;
    logic [IW-1:0]        n_seg;
    logic [IW-1:0]        n_lo;
    pli_pkg::t_region     n_region;

    assign wr_ok = i_wr_en && ({1'b0, i_wr.idx} < (XW+1)'(TAB_DEPTH));
    assign wa    = i_wr.idx[IW-1:0];

    always_comb begin
        for (int k = 0; k < TAB_DEPTH; k++) begin
            n_lt[k] = r_s1_q < r_xf[k];
        end
    end

    always_comb begin
        if (i_point_count == '0) begin
            n_last = '0;
        end else if (i_point_count >= CW'(TAB_DEPTH)) begin
            n_last = IW'(TAB_DEPTH - 1);
        end else begin
            n_last = IW'(i_point_count - CW'(1));
        end
    end

    // First breakpoint above the query among the inner points, else the last one.
    always_comb begin
        sel = r_s2_last;
        for (int k = TAB_DEPTH - 1; k >= 1; k--) begin
            if ((k < int'(r_s2_last)) && r_s2_lt[k]) begin
                sel = IW'(k);
            end
        end
        if (r_s2_lt[0]) begin
            n_region = pli_pkg::REGION_BELOW;
            n_seg    = '0;
        end else if (!r_s2_lt[r_s2_last]) begin
            n_region = pli_pkg::REGION_ABOVE;
            n_seg    = r_s2_last;
        end else begin
            n_region = pli_pkg::REGION_INTERIOR;
            n_seg    = sel;
        end
        n_lo = (n_seg == '0) ? '0 : n_seg - IW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_xf[wa] <= i_wr.x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_xm[wa] <= i_wr.x;
            r_ym[wa] <= i_wr.y;
        end
        if (i_en) begin
            r_s3_xl <= r_xm[n_lo];
            r_s3_xr <= r_xm[n_seg];
            r_s3_yl <= r_ym[n_lo];
            r_s3_yr <= r_ym[n_seg];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (i_en) begin
            r_s1_vld <= i_ev_en;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_q      <= i_q;
            r_s2_q      <= r_s1_q;
            r_s2_lt     <= n_lt;
            r_s2_last   <= n_last;
            r_s3_q      <= r_s2_q;
            r_s3_seg    <= n_seg;
            r_s3_region <= n_region;
        end
    end

    assign o_busy        = r_s1_vld || r_s2_vld;
    assign o_vld         = r_s3_vld;
    assign o_seg.q       = r_s3_q;
    assign o_seg.xl      = r_s3_xl;
    assign o_seg.xr      = r_s3_xr;
    assign o_seg.yl      = r_s3_yl;
    assign o_seg.yr      = r_s3_yr;
    assign o_seg.seg     = XW'(r_s3_seg);
    assign o_seg.region  = r_s3_region;

endmodule

@@ design/pli_mul.sv @@
// Operand preparation and the |e| * d product split into two partial products,
// plus the rounding offset: three stages. Depends on pli_pkg.
module pli_mul (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  pli_pkg::t_seg    i_seg,
    output logic             o_vld,
    output pli_pkg::t_div_in o_div
);

    localparam int DW = pli_pkg::DATA_W;
    localparam int HW = DW / 2;
    localparam int PW = DW + HW;

    logic              r4_vld;
    logic [DW-1:0]     r4_w;
    logic [DW-1:0]     r4_d;
    logic [DW-1:0]     r4_mag;
    pli_pkg::t_tag     r4_tag;
    logic              r5_vld;
    logic [DW-1:0]     r5_w;
    logic [PW-1:0]     r5_plo;
    logic [PW-1:0]     r5_phi;
    pli_pkg::t_tag     r5_tag;
    logic              r6_vld;
    pli_pkg::t_div_in  r6_div;

    logic              interior;
    logic signed [DW:0] e;
    logic [DW:0]       e_abs;
    pli_pkg::t_tag     n4_tag;
    logic [DW-1:0]     n4_w;
    logic [DW-1:0]     n4_d;
    logic [DW-1:0]     n4_mag;

    // Flat regions pass the end value through as a zero step over a unit width.
    always_comb begin
        interior   = (i_seg.region == pli_pkg::REGION_INTERIOR);
        e          = {i_seg.yr[DW-1], i_seg.yr} - {i_seg.yl[DW-1], i_seg.yl};
        e_abs      = e[DW] ? -e : e;
        n4_tag.seg    = i_seg.seg;
        n4_tag.region = i_seg.region;
        if (interior) begin
            n4_w          = i_seg.xr - i_seg.xl;
            n4_d          = i_seg.q - i_seg.xl;
            n4_mag        = e_abs[DW-1:0];
            n4_tag.base   = i_seg.yl;
            n4_tag.neg    = e[DW];
        end else begin
            n4_w          = DW'(1);
            n4_d          = '0;
            n4_mag        = '0;
            n4_tag.base   = i_seg.yr;
            n4_tag.neg    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld <= i_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_w       <= n4_w;
            r4_d       <= n4_d;
            r4_mag     <= n4_mag;
            r4_tag     <= n4_tag;
            r5_w       <= r4_w;
            r5_plo     <= PW'(r4_mag) * PW'(r4_d[HW-1:0]);
            r5_phi     <= PW'(r4_mag) * PW'(r4_d[DW-1:HW]);
            r5_tag     <= r4_tag;
            r6_div.num <= {r5_phi, {HW{1'b0}}} + pli_pkg::PROD_W'(r5_plo)
                          + pli_pkg::PROD_W'(r5_w >> 1);
            r6_div.dv  <= r5_w;
            r6_div.tag <= r5_tag;
        end
    end

    assign o_vld = r6_vld;
    assign o_div = r6_div;

endmodule

@@ design/pli_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, carrying the query's tag.
// Depends on pli_pkg.
module pli_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  pli_pkg::t_div_in           i_div,
    output logic                       o_vld,
    output logic [pli_pkg::DIV_W-1:0]  o_quo,
    output pli_pkg::t_tag              o_tag
);

    localparam int QW = pli_pkg::DIV_W;

    typedef struct packed {
        logic [QW-1:0] rem;
        logic [QW-1:0] num;
        logic [QW-1:0] quo;
        logic [QW-1:0] dv;
        pli_pkg::t_tag tag;
    } t_st;

    function automatic t_st div_step(t_st s);
        t_st         o;
        logic [QW:0] t;
        logic [QW:0] diff;
        logic        ge;
        t    = {s.rem, s.num[QW-1]};
        diff = t - {1'b0, s.dv};
        ge   = (t >= {1'b0, s.dv});
        o.rem = ge ? diff[QW-1:0] : t[QW-1:0];
        o.num = {s.num[QW-2:0], 1'b0};
        o.quo = {s.quo[QW-2:0], ge};
        o.dv  = s.dv;
        o.tag = s.tag;
        return o;
    endfunction

    logic [QW-1:0] r_vld;
    t_st           r_st [QW];
    t_st           n_st [QW];
    t_st           in_st;

    // The upper half of the dividend is always below the divisor, so QW bits suffice.
    assign in_st.rem = i_div.num[2*QW-1:QW];
    assign in_st.num = i_div.num[QW-1:0];
    assign in_st.quo = '0;
    assign in_st.dv  = i_div.dv;
    assign in_st.tag = i_div.tag;

    always_comb begin
        n_st[0] = div_step(in_st);
        for (int k = 1; k < QW; k++) begin
            n_st[k] = div_step(r_st[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QW-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_vld = r_vld[QW-1];
    assign o_quo = r_st[QW-1].quo;
    assign o_tag = r_st[QW-1].tag;

endmodule

@@ design/pli_obuf.sv @@
// Two-entry result buffer (output register and skid register) on the result channel.
// Depends on pli_pkg and pli_out_if.
module pli_obuf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pli_pkg::t_res i_data,
    output logic          o_room,
    pli_out_if.source     o_out
);

    logic          r_ov;
    logic          r_sv;
    pli_pkg::t_res r_od;
    pli_pkg::t_res r_sd;
    logic          n_ov;
    logic          n_sv;
    pli_pkg::t_res n_od;
    pli_pkg::t_res n_sd;
    logic          pop;

    assign pop = r_ov && o_out.ready;

    always_comb begin
        n_ov = r_ov;
        n_sv = r_sv;
        n_od = r_od;
        n_sd = r_sd;
        if (!r_ov || pop) begin
            if (r_sv) begin
                n_ov = 1'b1;
                n_od = r_sd;
                n_sv = i_push;
                n_sd = i_data;
            end else begin
                n_ov = i_push;
                n_od = i_data;
            end
        end else if (i_push) begin
            n_sv = 1'b1;
            n_sd = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_od <= n_od;
        r_sd <= n_sd;
    end

    // Room is taken from a register, so the upstream stall never sees o_out.ready.
    assign o_room         = !r_sv;
    assign o_out.valid    = r_ov;
    assign o_out.result_y = r_od.result_y;
    assign o_out.segment  = r_od.segment;
    assign o_out.region   = r_od.region;

endmodule

@@ design/piecewise_linear_interpolator.sv @@
// Piecewise linear interpolator with flat extrapolation over a table of Q16.16 breakpoints.
// An evaluate item passes the table, multiplier and divider stages, then the output buffer.
// Throughput: one evaluate item per cycle while the result buffer has room; a load item
// is held off while an evaluate sits in the first two stages, which still read the table.
// Reset (synchronous, active low) empties the pipeline and sets point_count to 1.
// Depends on pli_pkg, pli_ifs, pli_table, pli_mul, pli_div and pli_obuf.
module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = pli_pkg::DEF_MAX_POINTS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    pli_in_if.sink                     i_in,
    pli_out_if.source                  o_out,
    input  logic                       i_cfg_we,
    input  logic [pli_pkg::CNT_W-1:0]  i_cfg_wdata
);

    localparam int DW = pli_pkg::DATA_W;

    logic [pli_pkg::CNT_W-1:0]  r_point_count;

    logic                       w_en;
    logic                       w_busy;
    logic                       w_ld_acc;
    logic                       w_ev_acc;
    logic                       w_is_eval;
    pli_pkg::t_wr               w_wr;
    logic                       w_seg_vld;
    pli_pkg::t_seg              w_seg;
    logic                       w_div_vld;
    pli_pkg::t_div_in           w_div;
    logic                       w_quo_vld;
    logic [pli_pkg::DIV_W-1:0]  w_quo;
    pli_pkg::t_tag              w_tag;
    logic signed [DW+1:0]       w_sum;
    pli_pkg::t_res              w_res;

    // The single configuration register. Write it only while idle; no logic enforces it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= pli_pkg::CNT_W'(1);
        end else if (i_cfg_we) begin
            r_point_count <= i_cfg_wdata;
        end
    end

    // The whole pipeline advances together whenever the result buffer has a free
    // entry. That condition is registered, so no combinational path runs from the
    // result channel's ready to the input channel's ready. An evaluate item enters
    // on the same condition. A load item writes the table at once, and it must not
    // overtake an evaluate that has yet to compare against or read the table.
    assign w_is_eval = (i_in.func == pli_pkg::FUNC_EVAL);

    always_comb begin
        if (w_is_eval) begin
            i_in.ready = w_en;
        end else begin
            i_in.ready = !w_busy;
        end
    end

    assign w_ev_acc = i_in.valid && i_in.ready && w_is_eval;
    assign w_ld_acc = i_in.valid && i_in.ready && !w_is_eval;

    assign w_wr.idx = i_in.point_index;
    assign w_wr.x   = i_in.point_x;
    assign w_wr.y   = i_in.point_y;

    // Stages one to three: capture the query, compare it with every breakpoint in
    // parallel, then pick the segment and read its two end points.
    pli_table #(
        .MAX_POINTS (MAX_POINTS)
    ) u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_wr_en       (w_ld_acc),
        .i_wr          (w_wr),
        .i_ev_en       (w_ev_acc),
        .i_q           (i_in.query_x),
        .i_point_count (r_point_count),
        .o_busy        (w_busy),
        .o_vld         (w_seg_vld),
        .o_seg         (w_seg)
    );

    // Stages four to six: width, offset and step magnitude, the product in two halves,
    // and the sum that adds half the width for round-to-nearest.
    pli_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_seg_vld),
        .i_seg   (w_seg),
        .o_vld   (w_div_vld),
        .o_div   (w_div)
    );

    // Thirty-two divider stages, one quotient bit each.
    pli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_div_vld),
        .i_div   (w_div),
        .o_vld   (w_quo_vld),
        .o_quo   (w_quo),
        .o_tag   (w_tag)
    );

    // Apply the rounded step to the left ordinate with the sign of the rise, and
    // saturate to the signed 32-bit range. Flat regions add zero to yr instead.
    always_comb begin
        if (w_tag.neg) begin
            w_sum = {{2{w_tag.base[DW-1]}}, w_tag.base} - {2'b00, w_quo};
        end else begin
            w_sum = {{2{w_tag.base[DW-1]}}, w_tag.base} + {2'b00, w_quo};
        end
        if (!w_sum[DW+1] && (w_sum[DW:DW-1] != 2'b00)) begin
            w_res.result_y = pli_pkg::Q_MAX;
        end else if (w_sum[DW+1] && (w_sum[DW:DW-1] != 2'b11)) begin
            w_res.result_y = pli_pkg::Q_MIN;
        end else begin
            w_res.result_y = w_sum[DW-1:0];
        end
        w_res.segment = w_tag.seg;
        w_res.region  = w_tag.region;
    end

    pli_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_quo_vld && w_en),
        .i_data  (w_res),
        .o_room  (w_en),
        .o_out   (o_out)
    );

endmodule

@@ design/pli_checker.sv @@
// Port-level checks for the interpolator's result channel, bound to the top level.
// Depends on pli_pkg and piecewise_linear_interpolator.
module pli_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [pli_pkg::DATA_W-1:0]   i_result_y,
    input logic [pli_pkg::PT_IDX_W-1:0] i_segment,
    input logic [1:0]                   i_region
);

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result valid dropped before its transfer");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_result_y) && $stable(i_segment) && $stable(i_region))
        else $error("result payload changed while stalled");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_below_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_region == pli_pkg::REGION_BELOW) |-> i_segment == '0)
        else $error("low extrapolation with non-zero segment");

    a_interior_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_region == pli_pkg::REGION_INTERIOR) |-> i_segment != '0)
        else $error("interior result on segment zero");

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_result_y  (o_out.result_y),
    .i_segment   (o_out.segment),
    .i_region    (o_out.region)
);
